// File: rtl/dual_leg_lift_move_controller_core_macros.svh
// Assertion macros for the lift move controller core.
`ifndef DUAL_LEG_LIFT_MOVE_CONTROLLER_CORE_MACROS_SVH
`define DUAL_LEG_LIFT_MOVE_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DLLMC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dllmc check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DLLMC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dllmc check failed");

`endif

// File: rtl/dllmc_pkg.sv
// Types and constants shared by the lift move controller modules.
package dllmc_pkg;

  typedef enum logic [1:0] {
    ACT_POLL  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_RECAL = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_PREPARE = 4'd1,
    ST_DOWN    = 4'd2,
    ST_UP      = 4'd3,
    ST_STOP    = 4'd4,
    ST_DONE    = 4'd5,
    ST_RPREP   = 4'd6,
    ST_RON     = 4'd7,
    ST_RDONE   = 4'd8
  } mode_e;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_IDLE     = 4'd1,
    CMD_PREMOVE  = 4'd2,
    CMD_LOWER    = 4'd3,
    CMD_RAISE    = 4'd4,
    CMD_OK       = 4'd5,
    CMD_FINISH   = 4'd6,
    CMD_CALBEGIN = 4'd7,
    CMD_CALEND   = 4'd8
  } cmd_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LIMIT     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LIMIT     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_OFFSET = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DELTA     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_MS    = 3'd4;

  localparam logic [15:0] CAL_END_VALUE = 16'd99;
  localparam logic [7:0]  STAT_IDLE_A   = 8'h25;
  localparam logic [7:0]  STAT_IDLE_B   = 8'h60;
  localparam logic [7:0]  STAT_CAL      = 8'h01;
  localparam logic [15:0] POS_NO_CHANGE = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] enc_a;
    logic [7:0]  status_a;
    logic        fail_a;
    logic [15:0] enc_b;
    logic [7:0]  status_b;
    logic        fail_b;
    logic [31:0] now_ms;
    logic [15:0] position;
  } in_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] command_value;
    logic [3:0]  ctrl_state;
    logic        alarm;
    logic [15:0] target_now;
    logic        move_pending;
  } out_t;

  typedef struct packed {
    logic [15:0] min_limit;
    logic [15:0] max_limit;
    logic [15:0] target_offset;
    logic [15:0] max_delta;
    logic [15:0] timeout_ms;
  } cfg_t;

  // Classified request as held in the queue
  typedef struct packed {
    action_e     kind;
    logic        legs_ok;
    logic        pos_ok;
    logic [15:0] enc_a;
    logic [7:0]  status_a;
    logic        fail_a;
    logic [15:0] enc_b;
    logic [7:0]  status_b;
    logic        fail_b;
    logic [31:0] now_ms;
    logic [15:0] position;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/dllmc_front.sv
// Front end: accepts requests and classifies them into queue items.
module dllmc_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dllmc_pkg::in_t    in_data_i,
  input  dllmc_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output dllmc_pkg::item_t  item_o
);
  import dllmc_pkg::*;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    item_o.kind     = action_e'(in_data_i.action);
    item_o.legs_ok  = !in_data_i.fail_a && !in_data_i.fail_b;
    // zero and all-ones positions leave the target alone
    item_o.pos_ok   = (in_data_i.position != '0) && (in_data_i.position != POS_NO_CHANGE);
    item_o.enc_a    = in_data_i.enc_a;
    item_o.status_a = in_data_i.status_a;
    item_o.fail_a   = in_data_i.fail_a;
    item_o.enc_b    = in_data_i.enc_b;
    item_o.status_b = in_data_i.status_b;
    item_o.fail_b   = in_data_i.fail_b;
    item_o.now_ms   = in_data_i.now_ms;
    item_o.position = in_data_i.position;
  end

endmodule

// File: rtl/dllmc_queue.sv
// Short request queue between front end and back end.
module dllmc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dllmc_pkg::item_t   item_i,
  input  logic               pop_i,
  output dllmc_pkg::item_t   item_o,
  output dllmc_pkg::q_stat_t q_stat_o
);
  import dllmc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign q_stat_o.full  = (cnt_q == CntW'(Depth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !q_stat_o.full;
  assign do_pop         = pop_i && !q_stat_o.empty;
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/dllmc_back.sv
// Back end: leg readings, move state machine and registered result.
module dllmc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dllmc_pkg::cfg_t    cfg_i,
  input  dllmc_pkg::q_stat_t q_stat_i,
  input  dllmc_pkg::item_t   item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dllmc_pkg::out_t    out_data_o
);
  import dllmc_pkg::*;

  mode_e       mode_q, mode_d;
  logic [15:0] pos_a_q, pos_a_d, pos_b_q, pos_b_d;
  logic [7:0]  stat_a_q, stat_a_d, stat_b_q, stat_b_d;
  logic [15:0] goal_q, goal_d;
  logic        pend_q, pend_d;
  logic [31:0] last_q, last_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  function automatic logic leg_idle(input logic [7:0] s);
    return (s == '0) || (s == STAT_IDLE_A) || (s == STAT_IDLE_B);
  endfunction

  // Target clamped to the limits and to max_delta around the leg span
  function automatic logic [15:0] clamp_goal(input logic [15:0] g, input logic [15:0] lo,
                                             input logic [15:0] hi, input cfg_t c);
    logic [16:0] hi_t;
    logic [16:0] min_plus;
    logic [15:0] lo_t;
    hi_t     = {1'b0, lo} + {1'b0, c.max_delta};
    if (hi_t > {1'b0, c.max_limit}) hi_t = {1'b0, c.max_limit};
    min_plus = {1'b0, c.min_limit} + {1'b0, c.max_delta};
    lo_t     = ({1'b0, hi} > min_plus) ? hi - c.max_delta : c.min_limit;
    if (g < lo_t) return lo_t;
    if ({1'b0, g} > hi_t) return hi_t[15:0];
    return g;
  endfunction

  assign pop_o = !q_stat_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    logic [15:0] lo, hi;
    logic        idle2, timed_out, in_recal, emit_val;
    logic [16:0] bound;
    cmd_e        cmd;
    logic [15:0] val;
    logic        alarm;

    mode_d   = mode_q;
    pos_a_d  = pos_a_q;
    pos_b_d  = pos_b_q;
    stat_a_d = stat_a_q;
    stat_b_d = stat_b_q;
    goal_d   = goal_q;
    pend_d   = pend_q;
    last_d   = last_q;
    cmd      = CMD_NONE;
    val      = '0;
    alarm    = 1'b0;
    emit_val = 1'b0;
    lo       = '0;
    hi       = '0;
    idle2    = 1'b0;
    timed_out = 1'b0;
    bound    = '0;
    in_recal = (mode_q == ST_RPREP) || (mode_q == ST_RON) || (mode_q == ST_RDONE);

    if (pop_o) begin
      unique case (item_i.kind)
        ACT_POLL: begin
          if (!item_i.fail_a) begin
            if (item_i.enc_a != pos_a_q) last_d = item_i.now_ms;
            pos_a_d  = item_i.enc_a;
            stat_a_d = item_i.status_a;
          end
          if (!item_i.fail_b) begin
            if (item_i.enc_b != pos_b_q) last_d = item_i.now_ms;
            pos_b_d  = item_i.enc_b;
            stat_b_d = item_i.status_b;
          end
          lo        = (pos_a_d < pos_b_d) ? pos_a_d : pos_b_d;
          hi        = (pos_a_d > pos_b_d) ? pos_a_d : pos_b_d;
          idle2     = leg_idle(stat_a_d) && leg_idle(stat_b_d);
          timed_out = (item_i.now_ms - last_d) > {16'd0, cfg_i.timeout_ms};
          if (!item_i.legs_ok) begin
            alarm = pend_q;
          end else begin
            unique case (mode_q)
              ST_IDLE: begin
                if (pend_q && idle2) begin
                  mode_d = ST_PREPARE;
                end else begin
                  cmd = CMD_IDLE; emit_val = 1'b1;
                end
              end
              ST_PREPARE: begin
                if (goal_q < lo) begin
                  bound = {1'b0, cfg_i.min_limit} + {1'b0, cfg_i.target_offset};
                  if ({1'b0, goal_q} >= bound) goal_d = goal_q - cfg_i.target_offset;
                  mode_d = ST_DOWN;
                  last_d = item_i.now_ms;
                  cmd = CMD_PREMOVE; emit_val = 1'b1;
                end else if (goal_q > hi) begin
                  bound = {1'b0, goal_q} + {1'b0, cfg_i.target_offset};
                  if (bound <= {1'b0, cfg_i.max_limit}) goal_d = bound[15:0];
                  mode_d = ST_UP;
                  last_d = item_i.now_ms;
                  cmd = CMD_PREMOVE; emit_val = 1'b1;
                end else begin
                  pend_d = 1'b0;
                  mode_d = ST_IDLE;
                end
              end
              ST_DOWN: begin
                if (goal_q >= lo || timed_out) begin
                  mode_d = ST_STOP;
                end else begin
                  cmd = CMD_LOWER; emit_val = 1'b1;
                end
              end
              ST_UP: begin
                if (goal_q <= hi || timed_out) begin
                  mode_d = ST_STOP;
                end else begin
                  cmd = CMD_RAISE; emit_val = 1'b1;
                end
              end
              ST_STOP: begin
                mode_d = ST_DONE;
                cmd = CMD_OK; emit_val = 1'b1;
              end
              ST_DONE: begin
                if (idle2) begin
                  pend_d = 1'b0;
                  mode_d = ST_IDLE;
                end else begin
                  cmd = CMD_FINISH; emit_val = 1'b1;
                end
              end
              ST_RPREP: begin
                mode_d = ST_RON;
                cmd = CMD_PREMOVE; emit_val = 1'b1;
              end
              ST_RON: begin
                if (stat_a_d == STAT_CAL && stat_b_d == STAT_CAL && hi <= CAL_END_VALUE) begin
                  mode_d = ST_RDONE;
                end else begin
                  cmd = CMD_CALBEGIN;
                end
              end
              ST_RDONE: begin
                mode_d = ST_IDLE;
                cmd = CMD_CALEND;
                val = CAL_END_VALUE;
              end
              default: mode_d = ST_IDLE;
            endcase
            if (emit_val) val = clamp_goal(goal_d, lo, hi, cfg_i);
          end
        end
        ACT_SET: begin
          if (!in_recal && item_i.pos_ok) begin
            goal_d = item_i.position;
            pend_d = 1'b1;
          end
        end
        ACT_RECAL: begin
          if (!in_recal && leg_idle(stat_a_q) && leg_idle(stat_b_q)) begin
            pend_d = 1'b0;
            mode_d = ST_RPREP;
          end
        end
        ACT_NOP: ;
        default: ;
      endcase
    end

    out_d.command       = cmd;
    out_d.command_value = val;
    out_d.ctrl_state    = mode_d;
    out_d.alarm         = alarm;
    out_d.target_now    = goal_d;
    out_d.move_pending  = pend_d;

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ST_IDLE;
      pos_a_q     <= '0;
      pos_b_q     <= '0;
      stat_a_q    <= '0;
      stat_b_q    <= '0;
      goal_q      <= '0;
      pend_q      <= 1'b0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      pos_a_q     <= pos_a_d;
      pos_b_q     <= pos_b_d;
      stat_a_q    <= stat_a_d;
      stat_b_q    <= stat_b_d;
      goal_q      <= goal_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/dual_leg_lift_move_controller_core.sv
// Two-leg lift move controller: every request (poll, set target, recalibrate)
// gives exactly one result. Requests enter a queue of QueueDepth entries; the
// back end handles one request per cycle while the output is not stalled, so
// the block sustains one request per clock under that condition. A taken
// request is stored in the queue and, once popped from the queue head, its
// result is registered before it reaches the output. in_stall_o rises only
// when the queue is full, i.e. when the result side has been stalled for a
// while. Configuration writes are taken in any cycle (cfg_ready_o is always
// high).
`include "dual_leg_lift_move_controller_core_macros.svh"

module dual_leg_lift_move_controller_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dllmc_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dllmc_pkg::out_t                   out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dllmc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [15:0]                       cfg_data_i
);
  import dllmc_pkg::*;

  cfg_t    cfg_q, cfg_d;
  q_stat_t q_stat;
  item_t   push_item, head_item;
  logic    push, pop;
  logic    res_alarm, res_quiet, res_recal, res_cal_end, res_cal_val;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN_LIMIT:     cfg_d.min_limit     = cfg_data_i;
        CFG_MAX_LIMIT:     cfg_d.max_limit     = cfg_data_i;
        CFG_TARGET_OFFSET: cfg_d.target_offset = cfg_data_i;
        CFG_MAX_DELTA:     cfg_d.max_delta     = cfg_data_i;
        CFG_TIMEOUT_MS:    cfg_d.timeout_ms    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_limit     <= 16'd0;
      cfg_q.max_limit     <= 16'hFFFF;
      cfg_q.target_offset <= 16'd0;
      cfg_q.max_delta     <= 16'hFFFF;
      cfg_q.timeout_ms    <= 16'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dllmc_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .item_o     (push_item)
  );

  dllmc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .q_stat_o (q_stat)
  );

  dllmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  assign res_alarm   = out_valid_o && out_data_o.alarm;
  assign res_quiet   = out_data_o.move_pending && (out_data_o.command == CMD_NONE);
  assign res_recal   = out_valid_o && ((out_data_o.ctrl_state == ST_RPREP) ||
                                       (out_data_o.ctrl_state == ST_RON) ||
                                       (out_data_o.ctrl_state == ST_RDONE));
  assign res_cal_end = out_valid_o && (out_data_o.command == CMD_CALEND);
  assign res_cal_val = (out_data_o.command_value == CAL_END_VALUE);

  // an alarm never comes with a command and only while a move is pending
  `DLLMC_ASSERT_IMP(a_alarm_quiet, res_alarm, res_quiet)
  // recalibration always runs with no move pending
  `DLLMC_ASSERT_IMP(a_recal_no_pend, res_recal, !out_data_o.move_pending)
  // a queued request is always handed on once the output side is free
  `DLLMC_ASSERT_NXT(a_queue_drains, !q_stat.empty && !out_stall_i, out_valid_o)
  `DLLMC_ASSERT_IMP(a_cal_end_val, res_cal_end, res_cal_val)

endmodule
